/* rtl/isa_pkg.sv */
// isa_pkg: shared sizes, action and status codes, command struct and element
// conversions for the indexed shift array.
// No dependencies.
`default_nettype none

package isa_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_FIELDS_W  = ACTION_W + INDEX_W + VALUE_W;
  localparam int OUT_FIELDS_W = VALUE_W + STATUS_W + COUNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int GRP_N  = (DEPTH + LANES - 1) / LANES;
  localparam int GSEL_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int GRP_SLOTS = 2 ** GSEL_W;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_GET    = 3'd2,
    ACT_SET    = 3'd3,
    ACT_INSERT = 3'd4,
    ACT_REMOVE = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic load_req;
    logic gather;
    logic commit;
  } isa_cmd_t;

  function automatic elem_t to_elem(input logic signed [VALUE_W-1:0] v);
    logic signed [63:0] v64;
    v64 = 64'(v);
    return v64[ELEM_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_elem(input elem_t e);
    logic signed [ELEM_W-1:0] es;
    logic signed [63:0]       e64;
    es  = e;
    e64 = 64'(es);
    return e64[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/isa_ctrl.sv */
// isa_ctrl: request sequencer for the indexed shift array.
// Depends on isa_pkg; drives the command struct of isa_datapath.
`default_nettype none

module isa_ctrl
  import isa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output isa_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cmd.load_req = in_tvalid && in_tready_r;
    cmd.gather   = (state_r == S_GATHER);
    cmd.commit   = (state_r == S_COMMIT) && out_free;
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_COMMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= S_GATHER;
            in_tready_r <= 1'b0;
          end
        end
        S_GATHER: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/isa_datapath.sv */
// isa_datapath: element cells, live count, two-level read tree and result register.
// Depends on isa_pkg; sequenced by isa_ctrl through isa_cmd_t.
`default_nettype none

module isa_datapath
  import isa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire isa_cmd_t               cmd,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELDS_W;

  action_t            act_r;
  logic [CMP_W-1:0]   idx_r;
  elem_t              val_r;

  elem_t              cells_r [DEPTH];
  elem_t              cell_nxt [DEPTH];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  elem_t              lane_val [GRP_SLOTS][LANES];
  elem_t              grp_r [GRP_SLOTS];

  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   depth_c;
  logic [CMP_W-1:0]   rd_addr;
  logic [LANE_W-1:0]  lane;
  logic [GSEL_W-1:0]  gsel;
  status_t            st;
  logic               ok;

  logic [VALUE_W-1:0] rv_r;
  status_t            st_r;
  logic [COUNT_W-1:0] cnt_out_r;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r <= action_t'(in_tdata[ACTION_W-1:0]);
      idx_r <= CMP_W'(in_tdata[ACTION_W+INDEX_W-1:ACTION_W]);
      val_r <= to_elem(in_tdata[IN_FIELDS_W-1:ACTION_W+INDEX_W]);
    end
  end

  assign cnt_ext = CMP_W'(count_r);
  assign depth_c = CMP_W'(DEPTH);

  always_comb begin
    st = ST_OK;
    case (act_r) inside
      ACT_PUSH: begin
        if (cnt_ext >= depth_c) st = ST_FULL;
      end
      ACT_POP: begin
        if (count_r == '0) st = ST_EMPTY;
      end
      ACT_GET, ACT_SET, ACT_REMOVE: begin
        if (idx_r >= cnt_ext) st = ST_RANGE;
      end
      ACT_INSERT: begin
        if (idx_r > cnt_ext) st = ST_RANGE;
        else if (cnt_ext >= depth_c) st = ST_FULL;
      end
      default: st = ST_OK;
    endcase
  end

  assign ok = (st == ST_OK);

  always_comb begin
    count_nxt = count_r;
    case (act_r) inside
      ACT_PUSH, ACT_INSERT: begin
        if (ok) count_nxt = count_r + CNT_W'(1);
      end
      ACT_POP, ACT_REMOVE: begin
        if (ok) count_nxt = count_r - CNT_W'(1);
      end
      ACT_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  // per-cell next value: hold, load, or take a neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] POS = CMP_W'(i);
    elem_t prev_v;
    elem_t next_v;
    logic  has_next;

    if (i > 0) begin : g_prev
      assign prev_v = cells_r[i-1];
    end else begin : g_noprev
      assign prev_v = cells_r[i];
    end

    if (i < DEPTH - 1) begin : g_next
      assign next_v   = cells_r[i+1];
      assign has_next = 1'b1;
    end else begin : g_nonext
      assign next_v   = cells_r[i];
      assign has_next = 1'b0;
    end

    always_comb begin
      cell_nxt[i] = cells_r[i];
      if (ok) begin
        case (act_r)
          ACT_PUSH: begin
            if (cnt_ext == POS) cell_nxt[i] = val_r;
          end
          ACT_SET: begin
            if (idx_r == POS) cell_nxt[i] = val_r;
          end
          ACT_INSERT: begin
            if (idx_r == POS) cell_nxt[i] = val_r;
            else if (idx_r < POS) cell_nxt[i] = prev_v;
          end
          ACT_REMOVE: begin
            if (has_next && idx_r <= POS) cell_nxt[i] = next_v;
          end
          default: cell_nxt[i] = cells_r[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cells_r <= cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // read tree: lane select into group registers, then group select
  assign rd_addr = (act_r == ACT_POP) ? (cnt_ext - CMP_W'(1)) : idx_r;
  assign lane    = rd_addr[LANE_W-1:0];
  assign gsel    = GSEL_W'(rd_addr >> LANE_W);

  for (genvar g = 0; g < GRP_SLOTS; g++) begin : g_grp
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (g * LANES + l < DEPTH) begin : g_live
        assign lane_val[g][l] = cells_r[g*LANES+l];
      end else begin : g_pad
        assign lane_val[g][l] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.gather) begin
        grp_r[g] <= lane_val[g][lane];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (ok && (act_r == ACT_POP || act_r == ACT_GET)) begin
        rv_r <= from_elem(grp_r[gsel]);
      end else begin
        rv_r <= '0;
      end
      st_r      <= st;
      cnt_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_tdata = {{OUT_PAD{1'b0}}, cnt_out_r, st_r, rv_r};

endmodule

`default_nettype wire

/* rtl/indexed_shift_array_top.sv */
// indexed_shift_array_top: ordered word array with push, pop, get, set,
// insert, remove and clear. Depends on isa_pkg, isa_ctrl, isa_datapath.
//
//  channel  | ports                    | contents
//  ---------+--------------------------+----------------------------------
//  request  | in_tvalid/tready/tdata   | action, index, value
//  result   | out_tvalid/tready/tdata  | read_value, status, count
//
// Each request passes through accept, a gather cycle that loads the
// first level of the 8-way read tree, and a commit cycle that updates the
// cell row and count and loads the result register. The next request is
// accepted on the cycle after commit. Commit waits while an earlier result is
// still held. rst_n clears the count and handshake state; cell contents are
// not cleared.
`default_nettype none

module indexed_shift_array_top
  import isa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] action, [8:3] index, [40:9] value, [47:41] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [31:0] read_value, [33:32] status, [40:34] count, [47:41] zero
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  isa_cmd_t cmd;

  isa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  isa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
